// File: rtl/lsm_pkg.sv
// Shared types and constants of the list scheduling makespan block.
package lsm_pkg;

  localparam int DUR_W           = 16;
  localparam int OUT_W           = 40;
  localparam int SC_W            = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 40;
  localparam int MAX_SERVERS_DEF = 1024;
  localparam int TIME_WIDTH_DEF  = 40;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE     = 2'd1;

  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic             last_job;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] makespan;
    logic             meets_deadline;
  } out_t;

endpackage

// File: rtl/list_schedule_makespan.sv
// Top level of the list scheduling makespan block: configuration, heap memory, result register.
//
// Each job goes through one heap sift in a memory with a single read port and registered
// read data. A job that opens a new server places its finish time at the end of the heap
// and climbs it toward the root, reading and comparing one parent per level, until the
// parent is not later or the root is reached. A job that reuses the earliest free server
// reads the top, adds its duration and lets the new top sink level by level. At a level
// with two children the two children are read one after the other. The sift stops at a
// leaf or where no child holds an earlier finish time. No clearing pass is needed after
// reset or between batches: the busy count bounds every heap read. A result waits in an
// output register, and a following job is taken while it waits; only the next last job
// stalls on it.
module list_schedule_makespan
  import lsm_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  logic [SC_W-1:0]  server_count_r;
  logic [OUT_W-1:0] deadline_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_count_r <= SC_W'(1);
      deadline_r     <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SERVER_COUNT) begin
        server_count_r <= cfg_data[SC_W-1:0];
      end else if (cfg_index == CFG_DEADLINE) begin
        deadline_r <= cfg_data[OUT_W-1:0];
      end
    end
  end

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [TIME_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [TIME_WIDTH-1:0] wr_data;
  logic                  res_valid;
  logic                  res_ready;
  out_t                  res;

  lsm_heap_ram #(
    .DEPTH (MAX_SERVERS),
    .WIDTH (TIME_WIDTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lsm_ctrl #(
    .MAX_SERVERS (MAX_SERVERS),
    .TIME_WIDTH  (TIME_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .server_count (server_count_r),
    .deadline     (deadline_r),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  // The result register is free when empty or when its beat leaves this cycle.
  logic out_valid_r;
  out_t out_data_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/lsm_heap_ram.sv
// Single-port-read, single-port-write heap memory with registered read data.
module lsm_heap_ram
  import lsm_pkg::*;
#(
  parameter int DEPTH = MAX_SERVERS_DEF,
  parameter int WIDTH = TIME_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/lsm_ctrl.sv
// Job sequencer: heap insert and replace-top sifts, makespan tracking and result.
module lsm_ctrl
  import lsm_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int IDX_W       = $clog2(MAX_SERVERS),
  parameter int CNT_W       = $clog2(MAX_SERVERS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  input  logic [SC_W-1:0]       server_count,
  input  logic [OUT_W-1:0]      deadline,
  input  logic                  res_ready,
  output logic                  res_valid,
  output out_t                  res,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [TIME_WIDTH-1:0] rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [TIME_WIDTH-1:0] wr_data
);

  localparam int LW = (CNT_W > SC_W) ? CNT_W : SC_W;
  localparam int CW = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOP_RD, ST_TOP_WAIT, ST_UP_CHK, ST_UP_WAIT,
    ST_DN_CHK, ST_DN_L, ST_DN_R, ST_FIN
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      busy_r;
  logic [TIME_WIDTH-1:0] latest_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TIME_WIDTH-1:0] val_r;
  logic [TIME_WIDTH-1:0] lch_r;
  logic [DUR_W-1:0]      dur_r;
  logic                  last_r;

  // Effective server limit: zero means one, large counts clamp to the heap size.
  logic [LW-1:0] sc_ext;
  logic [LW-1:0] limit;
  logic          open_new;

  assign sc_ext   = LW'(server_count);
  assign limit    = (sc_ext == '0) ? LW'(1) :
                    (sc_ext > LW'(MAX_SERVERS)) ? LW'(MAX_SERVERS) : sc_ext;
  assign open_new = LW'(busy_r) < limit;

  // Heap index arithmetic.
  logic [IDX_W-1:0] parent;
  logic [CW-1:0]    child_l;
  logic [CW-1:0]    child_r;
  logic             l_in;
  logic             r_in;

  assign parent  = (idx_r - IDX_W'(1)) >> 1;
  assign child_l = {1'b0, idx_r, 1'b1};
  assign child_r = child_l + CW'(1);
  assign l_in    = child_l < CW'(busy_r);
  assign r_in    = child_r < CW'(busy_r);

  // Saturating finish time for the replace-top path.
  logic [TIME_WIDTH:0]   top_sum;
  logic [TIME_WIDTH-1:0] top_fin;

  assign top_sum = {1'b0, rd_data} + (TIME_WIDTH + 1)'(dur_r);
  assign top_fin = top_sum[TIME_WIDTH] ? '1 : top_sum[TIME_WIDTH-1:0];

  logic [TIME_WIDTH-1:0] in_fin;
  assign in_fin = TIME_WIDTH'(in_data.duration);

  // Makespan clipped to the result field.
  logic [OUT_W-1:0] ms;
  if (TIME_WIDTH > OUT_W) begin : g_sat
    assign ms = (|latest_r[TIME_WIDTH-1:OUT_W]) ? OUT_MAX : latest_r[OUT_W-1:0];
  end else begin : g_ext
    assign ms = OUT_W'(latest_r);
  end

  assign res.makespan       = ms;
  assign res.meets_deadline = (ms <= deadline);
  assign res_valid          = (state_r == ST_FIN) && last_r && res_ready;
  assign in_ready           = (state_r == ST_IDLE);

  // Memory requests and sift-down child selection.
  logic [IDX_W-1:0]      cand_idx;
  logic [TIME_WIDTH-1:0] cand_val;
  logic                  sink;

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = val_r;
    cand_idx = child_l[IDX_W-1:0];
    cand_val = rd_data;
    unique case (state_r)
      ST_TOP_RD: begin
        rd_en = 1'b1;
      end
      ST_UP_CHK: begin
        if (idx_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
        end
      end
      ST_UP_WAIT: begin
        wr_en = 1'b1;
        if (rd_data > val_r) begin
          wr_data = rd_data;
        end
      end
      ST_DN_CHK: begin
        if (l_in) begin
          rd_en   = 1'b1;
          rd_addr = child_l[IDX_W-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_DN_L: begin
        if (r_in) begin
          rd_en   = 1'b1;
          rd_addr = child_r[IDX_W-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end
      ST_DN_R: begin
        wr_en = 1'b1;
        if (rd_data < lch_r) begin
          cand_idx = child_r[IDX_W-1:0];
        end else begin
          cand_val = lch_r;
        end
      end
      default: begin
      end
    endcase
    sink = cand_val < val_r;
    if ((state_r == ST_DN_L || state_r == ST_DN_R) && sink) begin
      wr_data = cand_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= '0;
      latest_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dur_r  <= in_data.duration;
            last_r <= in_data.last_job;
            if (open_new) begin
              val_r  <= in_fin;
              idx_r  <= busy_r[IDX_W-1:0];
              busy_r <= busy_r + CNT_W'(1);
              if (in_fin > latest_r) begin
                latest_r <= in_fin;
              end
              state_r <= ST_UP_CHK;
            end else begin
              state_r <= ST_TOP_RD;
            end
          end
        end
        ST_TOP_RD: begin
          state_r <= ST_TOP_WAIT;
        end
        ST_TOP_WAIT: begin
          val_r <= top_fin;
          idx_r <= '0;
          if (top_fin > latest_r) begin
            latest_r <= top_fin;
          end
          state_r <= ST_DN_CHK;
        end
        ST_UP_CHK: begin
          state_r <= (idx_r == '0) ? ST_FIN : ST_UP_WAIT;
        end
        ST_UP_WAIT: begin
          if (rd_data > val_r) begin
            idx_r   <= parent;
            state_r <= ST_UP_CHK;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_DN_CHK: begin
          state_r <= l_in ? ST_DN_L : ST_FIN;
        end
        ST_DN_L: begin
          lch_r <= rd_data;
          if (r_in) begin
            state_r <= ST_DN_R;
          end else if (sink) begin
            idx_r   <= cand_idx;
            state_r <= ST_DN_CHK;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_DN_R: begin
          if (sink) begin
            idx_r   <= cand_idx;
            state_r <= ST_DN_CHK;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (res_ready) begin
            busy_r   <= '0;
            latest_r <= '0;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lsm_checker.sv
// Port-level checker for the list scheduling makespan block, bound to the top level.
module lsm_checker
  import lsm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_t                  out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // Mirror of the deadline register as seen on the configuration port.
  logic [OUT_W-1:0] deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_DEADLINE) begin
      deadline_r <= cfg_data[OUT_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed while stalled");

  a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second job taken while one is in flight");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.meets_deadline == (out_data.makespan <= deadline_r)))
    else $error("deadline verdict disagrees with makespan");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind list_schedule_makespan lsm_checker u_lsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
